@@ rtl/core/aavr_pkg.sv @@
// ============================================================================
// aavr_pkg: shared types and constants for axis-angle vector rotation
// Transaction payload types and fixed-point constants.
// ============================================================================
package aavr_pkg;

   // Component and angle widths are fixed by the payload types below.
   // The Q point of v never enters the arithmetic; FRAC_BITS documents it.
   localparam int COMP_WIDTH       = 32;
   localparam int FRAC_BITS        = 16;
   localparam int ANGLE_BITS       = 16;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_ENTRIES     = 24;

   localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;
   localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
   localparam logic signed [63:0] GAIN_Q30    = 64'sd652032874;

   typedef struct packed {
      logic signed [COMP_WIDTH-1:0] vx;
      logic signed [COMP_WIDTH-1:0] vy;
      logic signed [COMP_WIDTH-1:0] vz;
      logic signed [COMP_WIDTH-1:0] ax;
      logic signed [COMP_WIDTH-1:0] ay;
      logic signed [COMP_WIDTH-1:0] az;
      logic [ANGLE_BITS-1:0]        angle_turns;
   } req_type;

   typedef struct packed {
      logic signed [COMP_WIDTH-1:0] rx;
      logic signed [COMP_WIDTH-1:0] ry;
      logic signed [COMP_WIDTH-1:0] rz;
      logic                         axis_zero;
      logic                         saturated;
   } rsp_type;

   function automatic logic signed [31:0] atan_q30(input int idx);
      logic signed [31:0] t;
      case (idx)
         0: t = 32'sd843314856;   1: t = 32'sd497837829;
         2: t = 32'sd263043836;   3: t = 32'sd133525158;
         4: t = 32'sd67021686;    5: t = 32'sd33543515;
         6: t = 32'sd16775850;    7: t = 32'sd8388437;
         8: t = 32'sd4194282;     9: t = 32'sd2097149;
         10: t = 32'sd1048575;    11: t = 32'sd524287;
         12: t = 32'sd262143;     13: t = 32'sd131071;
         14: t = 32'sd65535;      15: t = 32'sd32767;
         16: t = 32'sd16383;      17: t = 32'sd8191;
         18: t = 32'sd4095;       19: t = 32'sd2047;
         20: t = 32'sd1023;       21: t = 32'sd511;
         22: t = 32'sd255;        default: t = 32'sd127;
      endcase
      return t;
   endfunction

endpackage

@@ rtl/core/axis_angle_vector_rotation.sv @@
// ============================================================================
// axis_angle_vector_rotation: Rodrigues rotation of a Q16.16 vector
// Rotates v about axis a by a fraction of a turn, saturating the result.
// ============================================================================
// Usage: a transaction on the req_ channel carries the vector, the axis
// (any length) and the angle; one transaction on the rsp_ channel returns
// the rotated vector with the axis_zero and saturated flags, in order.
// The datapath is a flat pipeline, one register stage per elementary step:
// capture and axis scaling, the squared length, a bit-per-stage square root
// whose first min(CORDIC_STEPS, 24) stages also carry the CORDIC iterations, a
// bit-per-stage restoring divider for the three axis components, then four
// product and sum stages. A new transaction is accepted every cycle unless the output stalls.
// The pipeline is 68 register stages deep (1 + 1 + 31 + 31 + 4); a result
// is offered on rsp_valid once its request has passed through all of them.
// Throughput is one transaction per cycle while rsp_ready stays high.
// The whole pipeline advances together: when rsp_ready is low while the
// output holds a result, every stage holds, and req_ready falls, so nothing
// is lost or repeated. Empty stages are not squeezed out during a stall.
// Reset clears only valid bits; data registers are not reset.
// ============================================================================
module axis_angle_vector_rotation #(
   parameter int CORDIC_STEPS = aavr_pkg::CORDIC_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  aavr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output aavr_pkg::rsp_type rsp_data
);
   localparam int COMP_WIDTH = aavr_pkg::COMP_WIDTH;
   localparam int ANGLE_BITS = aavr_pkg::ANGLE_BITS;
   localparam int NSQ   = 31;
   localparam int NDIV  = 31;
   localparam int NCOR  = (CORDIC_STEPS < aavr_pkg::ATAN_ENTRIES) ?
                          CORDIC_STEPS : aavr_pkg::ATAN_ENTRIES;
   localparam int T     = 2 + NSQ + NDIV;
   localparam int NTOT  = T + 3;

   typedef struct packed {
      logic signed [63:0] v0, v1, v2;
      logic               n0, n1, n2;
      logic [31:0]        m0, m1, m2;
      logic               zero;
      logic [63:0]        rem;
      logic [31:0]        root;
      logic [62:0]        dr0, dr1, dr2;
      logic [30:0]        q0, q1, q2;
      logic [1:0]         quad;
      logic signed [63:0] cx, cy, cz;
   } st_type;

   logic   adv;
   logic   [NTOT:0] vld_ff;
   st_type st_ff [T];
   st_type st_in [T];

   assign adv       = !vld_ff[NTOT] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[NTOT];

   function automatic logic signed [63:0] sx(input logic [COMP_WIDTH-1:0] r);
      return 64'(signed'(r));
   endfunction

   // Operands stay within 36 and 33 signed bits for every product formed here.
   function automatic logic signed [63:0] mq(input logic signed [63:0] a,
                                             input logic signed [63:0] b);
      logic signed [68:0] p;
      p = $signed(a[35:0]) * $signed(b[32:0]);
      return 64'(p >>> 30);
   endfunction

   // Stage 0: capture and find the axis magnitudes.
   always_comb begin
      logic signed [63:0] a0, a1, a2;
      logic [63:0] g0, g1, g2, mx;
      int bits;
      st_in[0] = st_ff[0];
      a0 = sx(req_data.ax); a1 = sx(req_data.ay); a2 = sx(req_data.az);
      g0 = a0 < 0 ? 64'(-a0) : 64'(a0);
      g1 = a1 < 0 ? 64'(-a1) : 64'(a1);
      g2 = a2 < 0 ? 64'(-a2) : 64'(a2);
      mx = g0;
      if (g1 > mx) mx = g1;
      if (g2 > mx) mx = g2;
      bits = 0;
      for (int i = 0; i < 64; i++) if (mx[i]) bits = i + 1;
      if (bits > 30) begin
         g0 = g0 >> (bits - 30); g1 = g1 >> (bits - 30); g2 = g2 >> (bits - 30);
      end else begin
         g0 = g0 << (30 - bits); g1 = g1 << (30 - bits); g2 = g2 << (30 - bits);
      end
      st_in[0].v0 = sx(req_data.vx);
      st_in[0].v1 = sx(req_data.vy);
      st_in[0].v2 = sx(req_data.vz);
      st_in[0].n0 = a0 < 0; st_in[0].n1 = a1 < 0; st_in[0].n2 = a2 < 0;
      st_in[0].m0 = g0[31:0]; st_in[0].m1 = g1[31:0]; st_in[0].m2 = g2[31:0];
      st_in[0].zero = (mx == 64'd0);
      st_in[0].quad = 2'(req_data.angle_turns[ANGLE_BITS-1 -: 2]);
      st_in[0].cz = 64'((64'(req_data.angle_turns[ANGLE_BITS-3:0]) *
                         aavr_pkg::HALF_PI_Q30) >>> (ANGLE_BITS - 2));
      st_in[0].cx = aavr_pkg::GAIN_Q30;
      st_in[0].cy = 64'sd0;
      st_in[0].rem = 64'd0; st_in[0].root = 32'd0;
      st_in[0].dr0 = '0; st_in[0].dr1 = '0; st_in[0].dr2 = '0;
      st_in[0].q0 = '0; st_in[0].q1 = '0; st_in[0].q2 = '0;
   end

   // Stage 1: squared length.
   always_comb begin
      st_in[1] = st_ff[0];
      st_in[1].rem = 64'(st_ff[0].m0) * 64'(st_ff[0].m0) +
                     64'(st_ff[0].m1) * 64'(st_ff[0].m1) +
                     64'(st_ff[0].m2) * 64'(st_ff[0].m2);
      st_in[1].root = 32'd0;
   end

   // Square root stages, one result bit each; CORDIC shares these stages.
   for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
      localparam int B = NSQ - 1 - g;
      always_comb begin
         logic [63:0] trial;
         logic signed [63:0] dx, dy;
         st_in[2+g] = st_ff[1+g];
         trial = (64'(st_ff[1+g].root) << (B + 1)) + (64'd1 << (2 * B));
         if (st_ff[1+g].rem >= trial) begin
            st_in[2+g].rem  = st_ff[1+g].rem - trial;
            st_in[2+g].root = st_ff[1+g].root | (32'd1 << B);
         end
         dx = st_ff[1+g].cy >>> g;
         dy = st_ff[1+g].cx >>> g;
         if (g < NCOR) begin
            if (st_ff[1+g].cz >= 0) begin
               st_in[2+g].cx = st_ff[1+g].cx - dx;
               st_in[2+g].cy = st_ff[1+g].cy + dy;
               st_in[2+g].cz = st_ff[1+g].cz - 64'(aavr_pkg::atan_q30(g));
            end else begin
               st_in[2+g].cx = st_ff[1+g].cx + dx;
               st_in[2+g].cy = st_ff[1+g].cy - dy;
               st_in[2+g].cz = st_ff[1+g].cz + 64'(aavr_pkg::atan_q30(g));
            end
         end
         if (g == NSQ - 1) begin
            st_in[2+g].dr0 = 63'(st_ff[1+g].m0);
            st_in[2+g].dr1 = 63'(st_ff[1+g].m1);
            st_in[2+g].dr2 = 63'(st_ff[1+g].m2);
         end
      end
   end

   // Restoring divider stages: quotient bit B of (m << 30) / root.
   for (genvar g = 0; g < NDIV; g++) begin : g_div
      localparam int B = NDIV - 1 - g;
      localparam int S = 2 + NSQ + g;
      always_comb begin
         logic [62:0] dv, r0, r1, r2;
         st_in[S] = st_ff[S-1];
         if (st_ff[S-1].zero) dv = 63'd1;
         else dv = 63'(st_ff[S-1].root) << B;
         r0 = st_ff[S-1].dr0;
         r1 = st_ff[S-1].dr1;
         r2 = st_ff[S-1].dr2;
         if (g == 0) begin
            r0 = r0 << 30; r1 = r1 << 30; r2 = r2 << 30;
         end
         st_in[S].dr0 = r0; st_in[S].dr1 = r1; st_in[S].dr2 = r2;
         if (r0 >= dv) begin
            st_in[S].dr0 = r0 - dv; st_in[S].q0[B] = 1'b1;
         end
         if (r1 >= dv) begin
            st_in[S].dr1 = r1 - dv; st_in[S].q1[B] = 1'b1;
         end
         if (r2 >= dv) begin
            st_in[S].dr2 = r2 - dv; st_in[S].q2[B] = 1'b1;
         end
      end
   end

   // Arithmetic tail, four stages after the divider.
   logic signed [63:0] k0_ff, k1_ff, k2_ff, c_ff, s_ff;
   logic signed [63:0] cr0_ff, cr1_ff, cr2_ff, dot_ff, t_ff;
   logic signed [63:0] p0_ff, p1_ff, p2_ff, e0_ff, e1_ff, e2_ff;
   logic signed [63:0] u0_ff, u1_ff, u2_ff;
   logic signed [63:0] r0_ff, r1_ff, r2_ff;
   logic               z1_ff, z2_ff, z3_ff, z4_ff;
   logic signed [63:0] v0a_ff, v1a_ff, v2a_ff, v0b_ff, v1b_ff, v2b_ff;
   logic signed [63:0] v0c_ff, v1c_ff, v2c_ff;
   logic signed [63:0] ka0_ff, ka1_ff, ka2_ff, sa_ff, ca_ff;

   localparam logic signed [63:0] MAXV = (64'sd1 <<< (COMP_WIDTH - 1)) - 1;
   localparam logic signed [63:0] MINV = -MAXV - 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NTOT-1:0], req_valid};
      end
      if (adv) begin
         for (int i = 0; i < T; i++) st_ff[i] <= st_in[i];
         // T: unit axis and trig mapping.
         ka0_ff <= st_ff[T-1].n0 ? -64'(st_ff[T-1].q0) : 64'(st_ff[T-1].q0);
         ka1_ff <= st_ff[T-1].n1 ? -64'(st_ff[T-1].q1) : 64'(st_ff[T-1].q1);
         ka2_ff <= st_ff[T-1].n2 ? -64'(st_ff[T-1].q2) : 64'(st_ff[T-1].q2);
         case (st_ff[T-1].quad)
            2'd0: begin ca_ff <= st_ff[T-1].cx;  sa_ff <= st_ff[T-1].cy;  end
            2'd1: begin ca_ff <= -st_ff[T-1].cy; sa_ff <= st_ff[T-1].cx;  end
            2'd2: begin ca_ff <= -st_ff[T-1].cx; sa_ff <= -st_ff[T-1].cy; end
            default: begin ca_ff <= st_ff[T-1].cy; sa_ff <= -st_ff[T-1].cx; end
         endcase
         v0a_ff <= st_ff[T-1].v0; v1a_ff <= st_ff[T-1].v1; v2a_ff <= st_ff[T-1].v2;
         z1_ff <= st_ff[T-1].zero;
         // T+1: cross and dot products.
         cr0_ff <= mq(v2a_ff, ka1_ff) - mq(v1a_ff, ka2_ff);
         cr1_ff <= mq(v0a_ff, ka2_ff) - mq(v2a_ff, ka0_ff);
         cr2_ff <= mq(v1a_ff, ka0_ff) - mq(v0a_ff, ka1_ff);
         dot_ff <= mq(v0a_ff, ka0_ff) + mq(v1a_ff, ka1_ff) + mq(v2a_ff, ka2_ff);
         k0_ff <= ka0_ff; k1_ff <= ka1_ff; k2_ff <= ka2_ff;
         c_ff <= ca_ff; s_ff <= sa_ff;
         v0b_ff <= v0a_ff; v1b_ff <= v1a_ff; v2b_ff <= v2a_ff;
         z2_ff <= z1_ff;
         // T+2: t and the first two terms.
         t_ff  <= mq(dot_ff, aavr_pkg::ONE_Q30 - c_ff);
         p0_ff <= mq(v0b_ff, c_ff) + mq(cr0_ff, s_ff);
         p1_ff <= mq(v1b_ff, c_ff) + mq(cr1_ff, s_ff);
         p2_ff <= mq(v2b_ff, c_ff) + mq(cr2_ff, s_ff);
         e0_ff <= k0_ff; e1_ff <= k1_ff; e2_ff <= k2_ff;
         v0c_ff <= v0b_ff; v1c_ff <= v1b_ff; v2c_ff <= v2b_ff;
         z3_ff <= z2_ff;
         // T+3: axial term.
         r0_ff <= p0_ff + mq(t_ff, e0_ff);
         r1_ff <= p1_ff + mq(t_ff, e1_ff);
         r2_ff <= p2_ff + mq(t_ff, e2_ff);
         u0_ff <= v0c_ff; u1_ff <= v1c_ff; u2_ff <= v2c_ff;
         z4_ff <= z3_ff;
      end
   end

   // Output saturation is taken from the last stage registers.
   always_comb begin
      logic signed [63:0] q [3];
      logic sat;
      q[0] = r0_ff; q[1] = r1_ff; q[2] = r2_ff;
      sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (q[i] > MAXV) begin q[i] = MAXV; sat = 1'b1; end
         else if (q[i] < MINV) begin q[i] = MINV; sat = 1'b1; end
      end
      if (z4_ff) begin
         q[0] = u0_ff; q[1] = u1_ff; q[2] = u2_ff; sat = 1'b0;
      end
      rsp_data.rx = q[0][COMP_WIDTH-1:0];
      rsp_data.ry = q[1][COMP_WIDTH-1:0];
      rsp_data.rz = q[2][COMP_WIDTH-1:0];
      rsp_data.axis_zero = z4_ff;
      rsp_data.saturated = sat;
   end

endmodule
